@@ rtl/spa_pkg.sv @@
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants for the swap page allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int PAGE_W     = 11;
   localparam int INDEX_W    = 10;
   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;
   localparam int HW_WORD_W  = PAGE_W - WORD_SHIFT;

   localparam logic [PAGE_W-1:0] POOL_RESET = 11'd1024;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_FETCH  = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

@@ rtl/spa_ram.sv @@
// ----------------------------------------------------------------------------
// spa_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/swap_page_allocator_top.sv @@
// ----------------------------------------------------------------------------
// swap_page_allocator_top
// Bitmap swap page allocator, first fit below a high-water mark.
// ----------------------------------------------------------------------------
// One word in, one word out per request. The used map lives in a RAM of
// 32-bit rows with one registered read per cycle; bits at or above the
// high-water mark are masked, so no clearing pass follows reset. A failed
// allocate and a free of an out-of-range page go from decode straight to
// the done state; any other free and an allocate that extends the
// high-water mark pass through a fetch state that reads and rewrites the
// row. An allocate that reuses a freed page scans rows from the bottom, one
// RAM read per cycle, until it reaches the row holding the lowest free page.
// The block takes one request at a time and is ready again in the cycle
// after it loads the result; a finished result waits in the output register
// while the next request is accepted, and a result that is still held
// stalls the block in its last state.
// ----------------------------------------------------------------------------
module swap_page_allocator_top
   import spa_pkg::*;
#(
   parameter int MAX_PAGES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [INDEX_W-1:0]  req_page_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PAGE_W-1:0]   rsp_page,
   output logic                rsp_full_res,
   output logic [PAGE_W-1:0]   rsp_used_count,
   output logic [PAGE_W-1:0]   rsp_high_water,
   input  logic                csr_wr_en,
   input  logic [PAGE_W-1:0]   csr_wr_data
);

   localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW    = (AW > HW_WORD_W) ? AW : HW_WORD_W;

   state_type              state_ff, state_in;
   logic                   cmd_ff, cmd_in;
   logic [INDEX_W-1:0]     idx_ff, idx_in;
   logic [PAGE_W-1:0]      target_ff, target_in;
   logic [AW-1:0]          scan_ptr_ff, scan_ptr_in;
   logic [AW-1:0]          chk_ff, chk_in;
   logic [PAGE_W-1:0]      used_ff, used_in;
   logic [PAGE_W-1:0]      hw_ff, hw_in;
   logic [PAGE_W-1:0]      pool_ff, pool_in;
   logic [PAGE_W-1:0]      res_page_ff, res_page_in;
   logic                   res_full_ff, res_full_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]      rsp_page_ff, rsp_page_in;
   logic                   rsp_full_ff, rsp_full_in;
   logic [PAGE_W-1:0]      rsp_used_ff, rsp_used_in;
   logic [PAGE_W-1:0]      rsp_hw_ff, rsp_hw_in;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic [AW-1:0]          ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_rd_data;

   logic [PAGE_W-1:0]      eff_pool;
   logic [CW-1:0]          chk_ext;
   logic [CW-1:0]          hw_word;
   logic [WORD_SHIFT-1:0]  hw_bit;
   logic [WORD_BITS-1:0]   scan_mask;
   logic [WORD_BITS-1:0]   free_bits;
   logic [WORD_SHIFT-1:0]  free_pos;
   logic [WORD_SHIFT-1:0]  tgt_bit;
   logic [WORD_BITS-1:0]   tgt_onehot;

   function automatic logic [AW-1:0] word_of(input logic [PAGE_W-1:0] p);
      word_of = AW'(p >> WORD_SHIFT);
   endfunction

   spa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign eff_pool = (32'(pool_ff) < MAX_PAGES) ? pool_ff : PAGE_W'(MAX_PAGES);

   // valid bits of the row under check: only pages below the high-water mark
   assign chk_ext = CW'(chk_ff);
   assign hw_word = CW'(hw_ff >> WORD_SHIFT);
   assign hw_bit  = hw_ff[WORD_SHIFT-1:0];

   always_comb begin
      if (chk_ext < hw_word) begin
         scan_mask = '1;
      end else if (chk_ext == hw_word) begin
         scan_mask = (WORD_BITS'(1) << hw_bit) - WORD_BITS'(1);
      end else begin
         scan_mask = '0;
      end
   end

   assign free_bits = ~ram_rd_data & scan_mask;

   // lowest free bit
   always_comb begin
      free_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_pos = WORD_SHIFT'(i);
         end
      end
   end

   assign tgt_bit    = target_ff[WORD_SHIFT-1:0];
   assign tgt_onehot = WORD_BITS'(1) << tgt_bit;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      target_in    = target_ff;
      scan_ptr_in  = scan_ptr_ff;
      chk_in       = chk_ff;
      used_in      = used_ff;
      hw_in        = hw_ff;
      res_page_in  = res_page_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_page_in  = rsp_page_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_hw_in    = rsp_hw_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = word_of(target_ff);
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = scan_ptr_ff;
      pool_in      = csr_wr_en ? csr_wr_data : pool_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               idx_in   = req_page_index;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_full_in = 1'b0;
            if (cmd_ff == CMD_ALLOC) begin
               if (used_ff < hw_ff) begin
                  ram_rd_addr = '0;
                  chk_in      = '0;
                  scan_ptr_in = AW'(1);
                  state_in    = ST_SCAN;
               end else if (hw_ff < eff_pool) begin
                  target_in   = hw_ff;
                  ram_rd_addr = word_of(hw_ff);
                  state_in    = ST_FETCH;
               end else begin
                  res_page_in = eff_pool;
                  res_full_in = 1'b1;
                  state_in    = ST_DONE;
               end
            end else begin
               res_page_in = PAGE_W'(idx_ff);
               if (PAGE_W'(idx_ff) < eff_pool) begin
                  target_in   = PAGE_W'(idx_ff);
                  ram_rd_addr = word_of(PAGE_W'(idx_ff));
                  state_in    = ST_FETCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_FETCH: begin
            ram_wr_en = 1'b1;
            if (cmd_ff == CMD_ALLOC) begin
               ram_wr_data = ram_rd_data | tgt_onehot;
               used_in     = used_ff + PAGE_W'(1);
               hw_in       = hw_ff + PAGE_W'(1);
               res_page_in = target_ff;
            end else if ((target_ff < hw_ff) && ((ram_rd_data & tgt_onehot) != '0)) begin
               ram_wr_data = ram_rd_data & ~tgt_onehot;
               used_in     = used_ff - PAGE_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (free_bits != '0) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = chk_ff;
               ram_wr_data = ram_rd_data | (WORD_BITS'(1) << free_pos);
               used_in     = used_ff + PAGE_W'(1);
               res_page_in = PAGE_W'({chk_ff, free_pos});
               state_in    = ST_DONE;
            end else begin
               chk_in      = scan_ptr_ff;
               scan_ptr_in = scan_ptr_ff + AW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_page_in  = res_page_ff;
               rsp_full_in  = res_full_ff;
               rsp_used_in  = used_ff;
               rsp_hw_in    = hw_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         hw_ff        <= '0;
         pool_ff      <= POOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         hw_ff        <= hw_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      target_ff   <= target_in;
      scan_ptr_ff <= scan_ptr_in;
      chk_ff      <= chk_in;
      res_page_ff <= res_page_in;
      res_full_ff <= res_full_in;
      rsp_page_ff <= rsp_page_in;
      rsp_full_ff <= rsp_full_in;
      rsp_used_ff <= rsp_used_in;
      rsp_hw_ff   <= rsp_hw_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_page       = rsp_page_ff;
   assign rsp_full_res   = rsp_full_ff;
   assign rsp_used_count = rsp_used_ff;
   assign rsp_high_water = rsp_hw_ff;

   a_used_below_mark : assert property (@(posedge clock) disable iff (reset)
      used_ff <= hw_ff)
      else $error("used count above high-water mark");

   a_mark_in_range : assert property (@(posedge clock) disable iff (reset)
      32'(hw_ff) <= MAX_PAGES)
      else $error("high-water mark beyond map size");

   a_scan_below_mark : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_mask != '0))
      else $error("scan ran past the high-water mark");

   a_accept_decides : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECIDE))
      else $error("accepted word not taken into decode");

   a_done_loads : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) |=>
         (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished word not presented");

endmodule

@@ dv/swap_page_allocator_top_tb.sv @@
// ----------------------------------------------------------------------------
// swap_page_allocator_top_tb
// Self-checking bench for the swap page allocator. A short directed run
// covers first-fit reuse, extension of the high-water mark, failed
// allocates, out-of-range frees and frees of idle pages. It also covers a
// pool shrunk below the mark and a pool above the page limit. Random phases
// then sweep the pool size from empty to past the limit, with sender gaps,
// receiver stalls and one long receiver hold-off. Every result word is
// checked against a behavioral model of the bitmap, the in-use count and
// the high-water mark.
// ----------------------------------------------------------------------------
module swap_page_allocator_top_tb
   import spa_pkg::*;
();

   localparam int PAGE_CAP       = 1024;
   localparam int SETTLE_CYCLES  = 48;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 8;

   class page_ledger;

      typedef struct packed {
         logic [PAGE_W-1:0] page;
         logic              full;
         logic [PAGE_W-1:0] used;
         logic [PAGE_W-1:0] high_water;
      } page_result_type;

      bit              in_use [PAGE_CAP];
      int unsigned     used_total;
      int unsigned     high_water;
      int unsigned     pool_pages;
      page_result_type awaited_results [$];
      int unsigned     errors;

      function new();
         foreach (in_use[i]) in_use[i] = 1'b0;
         used_total = 0;
         high_water = 0;
         pool_pages = 32'(POOL_RESET);
         errors     = 0;
      endfunction

      function void set_pool(input logic [PAGE_W-1:0] value);
         pool_pages = 32'(value);
      endfunction

      function int unsigned pool_limit();
         return (pool_pages < PAGE_CAP) ? pool_pages : PAGE_CAP;
      endfunction

      function void log_request(input logic command,
                                input logic [INDEX_W-1:0] page_index);
         page_result_type expected;
         int unsigned     pick;
         bit              found;
         found         = 1'b0;
         expected.full = 1'b0;
         if (command == CMD_ALLOC) begin
            if (used_total < high_water) begin
               for (int unsigned i = 0;
                    i < high_water && i < PAGE_CAP && !found; i++) begin
                  if (!in_use[i]) begin
                     found = 1'b1;
                     pick  = i;
                  end
               end
            end
            if (found) begin
               in_use[pick] = 1'b1;
               used_total++;
            end else if (high_water >= pool_limit()) begin
               expected.full = 1'b1;
               pick          = pool_limit();
            end else begin
               pick         = high_water;
               in_use[pick] = 1'b1;
               used_total++;
               high_water++;
            end
         end else begin
            pick = 32'(page_index);
            if (32'(page_index) < pool_limit() && in_use[page_index]) begin
               in_use[page_index] = 1'b0;
               used_total--;
            end
         end
         expected.page       = pick[PAGE_W-1:0];
         expected.used       = used_total[PAGE_W-1:0];
         expected.high_water = high_water[PAGE_W-1:0];
         awaited_results.push_back(expected);
      endfunction

      function void compare_result(input page_result_type actual);
         page_result_type expected;
         if (awaited_results.size() == 0) begin
            $error("result word with no request outstanding: page %0d", actual.page);
            errors++;
            return;
         end
         expected = awaited_results.pop_front();
         if (actual.page !== expected.page) begin
            $error("page: expected %0d, actual %0d", expected.page, actual.page);
            errors++;
         end
         if (actual.full !== expected.full) begin
            $error("full_res: expected %0d, actual %0d", expected.full, actual.full);
            errors++;
         end
         if (actual.used !== expected.used) begin
            $error("used_count: expected %0d, actual %0d", expected.used, actual.used);
            errors++;
         end
         if (actual.high_water !== expected.high_water) begin
            $error("high_water: expected %0d, actual %0d", expected.high_water,
                   actual.high_water);
            errors++;
         end
      endfunction

   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_command    = CMD_ALLOC;
   logic [INDEX_W-1:0]  req_page_index = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [PAGE_W-1:0]   rsp_page;
   logic                rsp_full_res;
   logic [PAGE_W-1:0]   rsp_used_count;
   logic [PAGE_W-1:0]   rsp_high_water;
   logic                csr_wr_en      = 1'b0;
   logic [PAGE_W-1:0]   csr_wr_data    = '0;

   page_ledger ledger = new();

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   bit          hold_pending  = 1'b0;
   int unsigned quiet_cycles  = 0;

   int unsigned phase_pool      [PHASES] = '{0, 1, 2, 40, 200, 1024, 2047, 300};
   int unsigned phase_words     [PHASES] = '{40, 40, 40, 120, 160, 400, 650, 60};
   int unsigned phase_alloc_pct [PHASES] = '{50, 50, 50, 60, 70, 90, 98, 50};
   int unsigned idle_profile    [4]      = '{0, 56, 0, 27};
   int unsigned stall_profile   [4]      = '{0, 0, 56, 27};

   swap_page_allocator_top #(
      .MAX_PAGES (PAGE_CAP)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_page_index (req_page_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_page       (rsp_page),
      .rsp_full_res   (rsp_full_res),
      .rsp_used_count (rsp_used_count),
      .rsp_high_water (rsp_high_water),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #6 clock = ~clock;

   // receiver, with an optional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         ledger.compare_result({rsp_page, rsp_full_res, rsp_used_count, rsp_high_water});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // entered and left at a falling edge; valid stays up between words unless a sender gap drops it
   task automatic send_word(input logic command, input logic [INDEX_W-1:0] page_index);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= command;
      req_page_index <= page_index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.log_request(command, page_index);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (ledger.awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_pool(input logic [PAGE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      ledger.set_pool(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count, input int unsigned alloc_pct);
      logic               command;
      logic [INDEX_W-1:0] page_index;
      for (int unsigned k = 0; k < count; k++) begin
         command = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
         if (command == CMD_FREE && ledger.high_water != 0 && $urandom_range(1) == 1) begin
            page_index = INDEX_W'($urandom_range(ledger.high_water - 1));
         end else begin
            page_index = INDEX_W'($urandom_range(PAGE_CAP - 1));
         end
         send_word(command, page_index);
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // free before anything is handed out, then first fit and extension
      send_word(CMD_FREE, 10'd0);
      send_word(CMD_FREE, 10'd1023);
      send_word(CMD_ALLOC, 10'h3FF);
      send_word(CMD_ALLOC, 10'h000);
      send_word(CMD_ALLOC, 10'h2AA);
      send_word(CMD_ALLOC, 10'h155);
      send_word(CMD_FREE, 10'd1);
      send_word(CMD_FREE, 10'd1);
      send_word(CMD_ALLOC, 10'd0);
      send_word(CMD_FREE, 10'd0);
      send_word(CMD_FREE, 10'd2);
      send_word(CMD_ALLOC, 10'd0);
      send_word(CMD_ALLOC, 10'd0);
      send_word(CMD_ALLOC, 10'd0);
      settle();

      // pool shrunk below the high-water mark
      write_pool(11'd2);
      send_word(CMD_FREE, 10'd3);
      send_word(CMD_FREE, 10'd1);
      send_word(CMD_ALLOC, 10'd0);
      send_word(CMD_ALLOC, 10'd0);
      send_word(CMD_FREE, 10'd1023);
      settle();

      // pool above the page limit
      write_pool(11'd2047);
      send_word(CMD_ALLOC, 10'd0);
      send_word(CMD_FREE, 10'd5);
      send_word(CMD_ALLOC, 10'd0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = idle_profile[p % 4];
         stall_pct     = stall_profile[p % 4];
         write_pool(PAGE_W'(phase_pool[p]));
         if (p == 4) hold_pending = 1'b1;
         run_random(phase_words[p], phase_alloc_pct[p]);
         settle();
      end

      if (ledger.errors == 0 && ledger.awaited_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/spa_pkg.sv
rtl/spa_ram.sv
rtl/swap_page_allocator_top.sv
dv/swap_page_allocator_top_tb.sv
